// ===== src/tvi_pkg.sv =====
// ============================================================================
// tvi_pkg
// Types and constants shared by the velocity interpolator modules.
// ============================================================================
`default_nettype none
package tvi_pkg;
    localparam int unsigned DEPTH_DEF     = 64;
    localparam int unsigned TIME_BITS_DEF = 32;
    localparam int unsigned VW            = 32;
    localparam logic [31:0] WINDOW_RESET  = 32'd1000000;

    typedef enum logic [1:0] {
        CMD_ADD    = 2'd0,
        CMD_NEWEST = 2'd1,
        CMD_AT     = 2'd2,
        CMD_NONE   = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_EMPTY  = 2'd1,
        ST_OLD    = 2'd2,
        ST_FUTURE = 2'd3
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_PRUNE_RD,
        S_PRUNE_CHK,
        S_DECIDE,
        S_ENDS_RD,
        S_ENDS_CHK,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_DIV,
        S_DIV_FIN,
        S_DONE
    } t_state;

    // controller -> datapath commands
    typedef struct packed {
        logic       capture;   // latch the command's fields
        logic       rd_oldest; // read slot at oldest pointer
        logic       pop;       // drop oldest entry
        logic       rd_newest; // read newest entry
        logic       rd_scan;   // read scan entry k and k+1
        logic       scan_next; // advance scan index
        logic       scan_clr;  // clear scan index
        logic       write;     // append the captured sample
        logic       div_start; // load interpolation unit
        logic       div_step;  // one interpolation step
        logic       emit;      // drive the result strobe
    } t_ctl;

    // datapath -> controller status
    typedef struct packed {
        t_cmd cmd;
        logic empty;
        logic prune_hit;  // oldest stamp at or below the limit
        logic add_ok;     // captured sample may be stored
        logic too_old;
        logic future;
        logic exact;      // scan entry matches target
        logic bracket;    // target between scan entry and next
        logic scan_last;  // no further pair to scan
        logic div_done;
    } t_sts;
endpackage
`default_nettype wire

// ===== src/tvi_ctrl.sv =====
// ============================================================================
// tvi_ctrl
// Sequencer: prune, then add or answer a query through a scan and divide.
// ============================================================================
`default_nettype none
module tvi_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  wire tvi_pkg::t_sts i_sts,
    output tvi_pkg::t_ctl      o_ctl,
    output logic               o_busy
);
    import tvi_pkg::*;

    t_state r_state, n_state;

    // hold state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:      if (i_start) n_state = S_PRUNE_RD;
            S_PRUNE_RD:  n_state = S_PRUNE_CHK;
            S_PRUNE_CHK: n_state = (!i_sts.empty && i_sts.prune_hit) ? S_PRUNE_RD : S_DECIDE;
            S_DECIDE: begin
                unique case (i_sts.cmd) inside
                    CMD_ADD, CMD_NONE:  n_state = S_IDLE;
                    CMD_NEWEST, CMD_AT: n_state = i_sts.empty ? S_DONE : S_ENDS_RD;
                    default:            n_state = S_IDLE;
                endcase
            end
            S_ENDS_RD:   n_state = S_ENDS_CHK;
            S_ENDS_CHK: begin
                if (i_sts.cmd == CMD_NEWEST || i_sts.too_old || i_sts.future) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_SCAN_RD;
                end
            end
            S_SCAN_RD:   n_state = S_SCAN_CHK;
            S_SCAN_CHK: begin
                if (i_sts.exact) begin
                    n_state = S_DONE;
                end else if (i_sts.bracket) begin
                    n_state = S_DIV;
                end else if (i_sts.scan_last) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_SCAN_RD;
                end
            end
            S_DIV:       n_state = i_sts.div_done ? S_DIV_FIN : S_DIV;
            S_DIV_FIN:   n_state = S_DONE;
            S_DONE:      n_state = S_IDLE;
            default:     n_state = S_IDLE;
        endcase
    end

    // outputs; hold off new items while in reset
    always_comb begin
        o_ctl = '0;
        o_busy = (r_state != S_IDLE) || !i_rst_n;
        unique case (r_state)
            S_IDLE: begin
                o_ctl.capture = i_start;
            end
            S_PRUNE_RD:  o_ctl.rd_oldest = 1'b1;
            S_PRUNE_CHK: o_ctl.pop = !i_sts.empty && i_sts.prune_hit;
            S_DECIDE: begin
                o_ctl.write = (i_sts.cmd == CMD_ADD) && i_sts.add_ok;
                o_ctl.scan_clr = 1'b1;
            end
            S_ENDS_RD: o_ctl.rd_newest = 1'b1;
            S_SCAN_RD: o_ctl.rd_scan = 1'b1;
            S_SCAN_CHK: begin
                o_ctl.scan_next = !i_sts.exact && !i_sts.bracket;
                o_ctl.div_start = !i_sts.exact && i_sts.bracket;
                o_ctl.rd_scan = 1'b0;
            end
            S_DIV:    o_ctl.div_step = 1'b1;
            S_DIV_FIN: o_ctl.div_step = 1'b0;
            S_DONE:   o_ctl.emit = 1'b1;
            default: ;
        endcase
    end
endmodule
`default_nettype wire

// ===== src/tvi_lerp.sv =====
// ============================================================================
// tvi_lerp
// Bit-serial rounded multiply-divide for the three axes, one bit a cycle while i_step is high.
// ============================================================================
`default_nettype none
module tvi_lerp #(
    parameter int unsigned TIME_BITS = tvi_pkg::TIME_BITS_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_load,
    input  wire logic                 i_step,
    input  wire logic [TIME_BITS-1:0] i_dt,
    input  wire logic [TIME_BITS-1:0] i_span,
    input  wire logic [31:0]          i_v0 [3],
    input  wire logic [31:0]          i_v1 [3],
    output logic [31:0]               o_v [3],
    output logic                      o_done
);
    import tvi_pkg::*;
    localparam int unsigned MB = 33;          // magnitude bits
    localparam int unsigned QB = MB + 1;
    localparam int unsigned RB = TIME_BITS + 1;
    localparam int unsigned CB = $clog2(MB + 1);

    logic [TIME_BITS-1:0] r_dt, r_span;
    logic [MB-1:0]        r_mag [3];
    logic                 r_neg [3];
    logic [31:0]          r_v0 [3];
    logic [QB-1:0]        r_q [3];
    logic [RB-1:0]        r_r [3];
    logic [CB-1:0]        r_cnt;
    logic                 r_run;

    assign o_done = r_run && (r_cnt == '0);

    // load operands, then one bit of the product per step, msb first
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run <= 1'b0;
            r_cnt <= '0;
        end else if (i_load) begin
            r_run <= 1'b1;
            r_cnt <= CB'(MB);
        end else if (i_step && r_cnt != '0) begin
            r_cnt <= r_cnt - 1'b1;
        end else if (i_step) begin
            r_run <= 1'b0;
        end
    end

    for (genvar a = 0; a < 3; a++) begin : g_ax
        logic signed [32:0] w_d;
        logic [RB-1:0]      w_r2, w_r3;
        logic [QB-1:0]      w_q2;
        logic [RB-1:0]      w_c, w_b;
        logic               w_bit;
        assign w_d = $signed({i_v1[a][31], i_v1[a]}) - $signed({i_v0[a][31], i_v0[a]});
        assign w_c = RB'(r_span);
        assign w_b = RB'(r_dt);
        assign w_bit = r_mag[a][r_cnt - 1'b1];

        // doubling step then conditional add of dt, reduced mod span
        always_comb begin
            w_q2 = r_q[a] << 1;
            if (r_r[a] >= w_c - r_r[a]) begin
                w_r2 = r_r[a] - (w_c - r_r[a]);
                w_q2 = w_q2 + 1'b1;
            end else begin
                w_r2 = r_r[a] + r_r[a];
            end
            w_r3 = w_r2;
            if (w_bit) begin
                if (w_r2 >= w_c - w_b) begin
                    w_r3 = w_r2 - (w_c - w_b);
                    w_q2 = w_q2 + 1'b1;
                end else begin
                    w_r3 = w_r2 + w_b;
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_load) begin
                r_neg[a] <= w_d[32];
                r_mag[a] <= w_d[32] ? MB'(-w_d) : MB'(w_d);
                r_v0[a]  <= i_v0[a];
                r_q[a]   <= '0;
                r_r[a]   <= '0;
            end else if (i_step && r_cnt != '0) begin
                r_q[a] <= w_q2;
                r_r[a] <= w_r3;
            end else if (i_step && r_run) begin
                // final rounding
                if (r_r[a] >= w_c - r_r[a]) r_q[a] <= r_q[a] + 1'b1;
            end
        end
        assign o_v[a] = r_neg[a] ? r_v0[a] - r_q[a][31:0] : r_v0[a] + r_q[a][31:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_dt   <= i_dt;
            r_span <= i_span;
        end
    end
endmodule
`default_nettype wire

// ===== src/tvi_dpath.sv =====
// ============================================================================
// tvi_dpath
// Sample ring, pruning compare, scan compares and result register.
// ============================================================================
`default_nettype none
module tvi_dpath #(
    parameter int unsigned DEPTH     = tvi_pkg::DEPTH_DEF,
    parameter int unsigned TIME_BITS = tvi_pkg::TIME_BITS_DEF
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire tvi_pkg::t_ctl i_ctl,
    output tvi_pkg::t_sts      o_sts,
    input  wire logic          i_cfg_we,
    input  wire logic [31:0]   i_cfg_wdata,
    input  wire logic [1:0]    i_command,
    input  wire logic [31:0]   i_now_time,
    input  wire logic [31:0]   i_sample_time,
    input  wire logic [31:0]   i_in_vel_x,
    input  wire logic [31:0]   i_in_vel_y,
    input  wire logic [31:0]   i_in_vel_z,
    input  wire logic [31:0]   i_target_time,
    output logic               o_valid,
    output logic [1:0]         o_status,
    output logic [31:0]        o_out_time,
    output logic [31:0]        o_out_vel_x,
    output logic [31:0]        o_out_vel_y,
    output logic [31:0]        o_out_vel_z
);
    import tvi_pkg::*;
    localparam int unsigned AW = $clog2(DEPTH);
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam int unsigned TB = TIME_BITS;
    localparam int unsigned EW = TB + 3 * VW;

    logic [EW-1:0] r_mem [DEPTH];
    logic [EW-1:0] r_rd0, r_rd1;
    logic [AW-1:0] r_old;
    logic [CW-1:0] r_cnt;
    logic [AW-1:0] r_newest_idx;
    logic [TB-1:0] r_newest_t;
    logic          r_has_newest;
    logic [31:0]   r_win;
    logic [1:0]    r_cmd;
    logic [TB-1:0] r_now, r_st, r_tgt;
    logic [31:0]   r_vx, r_vy, r_vz;
    logic [CW-1:0] r_k;

    function automatic logic [AW-1:0] wrap(input logic [CW:0] s);
        logic [CW:0] d;
        d = (CW+1)'(DEPTH);
        return (s >= d) ? AW'(s - d) : AW'(s);
    endfunction

    // prune limit
    logic [TB:0]   w_win;
    logic          w_noprune;
    logic [TB-1:0] w_lim;
    assign w_win = (TB + 1)'(r_win);
    assign w_noprune = {1'b0, r_now} < w_win;
    assign w_lim = TB'({1'b0, r_now} - w_win);

    logic [TB-1:0] w_t0, w_t1;
    assign w_t0 = r_rd0[EW-1 -: TB];
    assign w_t1 = r_rd1[EW-1 -: TB];

    logic w_done;
    logic [31:0] w_lv [3];
    logic [31:0] w_v0 [3], w_v1 [3];
    assign w_v0[0] = r_rd0[3*VW-1 -: VW];
    assign w_v0[1] = r_rd0[2*VW-1 -: VW];
    assign w_v0[2] = r_rd0[VW-1:0];
    assign w_v1[0] = r_rd1[3*VW-1 -: VW];
    assign w_v1[1] = r_rd1[2*VW-1 -: VW];
    assign w_v1[2] = r_rd1[VW-1:0];

    // status to controller
    always_comb begin
        o_sts.cmd = t_cmd'(r_cmd);
        o_sts.empty = (r_cnt == '0);
        o_sts.prune_hit = !w_noprune && (w_t0 <= w_lim);
        o_sts.add_ok = !(!w_noprune && r_st <= w_lim) &&
                       !(r_has_newest && r_cnt != '0 && r_st <= r_newest_t);
        o_sts.too_old = w_t0 > r_tgt;
        o_sts.future = w_t1 < r_tgt;
        o_sts.exact = w_t0 == r_tgt;
        o_sts.bracket = (r_k + 1'b1 < r_cnt) && (w_t0 < r_tgt) && (r_tgt < w_t1);
        o_sts.scan_last = !(r_k + 1'b1 < r_cnt);
        o_sts.div_done = w_done;
    end

    tvi_lerp #(.TIME_BITS(TB)) u_lerp (
        .i_clk (i_clk), .i_rst_n (i_rst_n),
        .i_load (i_ctl.div_start), .i_step (i_ctl.div_step),
        .i_dt (r_tgt - w_t0), .i_span (w_t1 - w_t0),
        .i_v0 (w_v0), .i_v1 (w_v1), .o_v (w_lv), .o_done (w_done)
    );

    // ring memory: one write port, registered reads
    logic [CW:0] w_wslot;
    assign w_wslot = {1'b0, r_old} + ((r_cnt == CW'(DEPTH)) ? (CW+1)'(0) : (CW+1)'(r_cnt));
    always_ff @(posedge i_clk) begin
        if (i_ctl.write) begin
            r_mem[wrap(w_wslot)] <= {r_st, r_vx, r_vy, r_vz};
        end
        if (i_ctl.rd_oldest) begin
            r_rd0 <= r_mem[r_old];
        end
        if (i_ctl.rd_newest) begin
            r_rd0 <= r_mem[r_old];
            r_rd1 <= r_mem[r_newest_idx];
        end
        if (i_ctl.rd_scan) begin
            r_rd0 <= r_mem[wrap({1'b0, r_old} + (CW+1)'(r_k))];
            r_rd1 <= r_mem[wrap({1'b0, r_old} + (CW+1)'(r_k) + 1'b1)];
        end
    end

    // pointers, count and newest stamp cache
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_old <= '0;
            r_cnt <= '0;
            r_win <= WINDOW_RESET;
            r_has_newest <= 1'b0;
            r_k <= '0;
        end else begin
            if (i_cfg_we) r_win <= i_cfg_wdata;
            if (i_ctl.pop) begin
                r_old <= wrap((CW+1)'(r_old) + 1'b1);
                r_cnt <= r_cnt - 1'b1;
            end
            if (i_ctl.write) begin
                r_newest_idx <= wrap(w_wslot);
                r_newest_t <= r_st;
                r_has_newest <= 1'b1;
                if (r_cnt == CW'(DEPTH)) begin
                    r_old <= wrap((CW+1)'(r_old) + 1'b1);
                end else begin
                    r_cnt <= r_cnt + 1'b1;
                end
            end
            if (i_ctl.scan_clr) r_k <= '0;
            else if (i_ctl.scan_next) r_k <= r_k + 1'b1;
        end
    end

    // latch command fields
    always_ff @(posedge i_clk) begin
        if (i_ctl.capture) begin
            r_cmd <= i_command;
            r_now <= TB'(i_now_time);
            r_st  <= TB'(i_sample_time);
            r_tgt <= TB'(i_target_time);
            r_vx  <= i_in_vel_x;
            r_vy  <= i_in_vel_y;
            r_vz  <= i_in_vel_z;
        end
    end

    // result strobe
    logic r_rv;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rv <= 1'b0;
        end else begin
            r_rv <= i_ctl.emit;
        end
    end

    // record the answer when it becomes known
    logic [1:0]  r_os;
    logic [31:0] r_ot, r_ox, r_oy, r_oz;
    logic r_ends_chk, r_scan_chk, r_div_fin;
    logic w_ends_chk, w_scan_chk;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ends_chk <= 1'b0;
            r_scan_chk <= 1'b0;
            r_div_fin <= 1'b0;
        end else begin
            r_ends_chk <= i_ctl.rd_newest;
            r_scan_chk <= i_ctl.rd_scan;
            r_div_fin <= w_done && i_ctl.div_step;
        end
    end
    assign w_ends_chk = r_ends_chk;
    assign w_scan_chk = r_scan_chk;

    always_ff @(posedge i_clk) begin
        if (i_ctl.scan_clr) begin
            r_os <= ST_EMPTY;
            r_ot <= '0; r_ox <= '0; r_oy <= '0; r_oz <= '0;
        end else if (w_ends_chk) begin
            if (r_cmd != CMD_NEWEST && w_t0 > r_tgt) begin
                r_os <= ST_OLD;
                r_ot <= 32'(r_tgt);
                r_ox <= '0; r_oy <= '0; r_oz <= '0;
            end else if (r_cmd != CMD_NEWEST && w_t1 < r_tgt) begin
                r_os <= ST_FUTURE;
                r_ot <= 32'(r_tgt);
                r_ox <= '0; r_oy <= '0; r_oz <= '0;
            end else begin
                r_os <= ST_OK;
                r_ot <= 32'(w_t1);
                r_ox <= w_v1[0]; r_oy <= w_v1[1]; r_oz <= w_v1[2];
            end
        end else if (w_scan_chk && w_t0 == r_tgt) begin
            r_os <= ST_OK;
            r_ot <= 32'(r_tgt);
            r_ox <= w_v0[0]; r_oy <= w_v0[1]; r_oz <= w_v0[2];
        end else if (r_div_fin) begin
            r_os <= ST_OK;
            r_ot <= 32'(r_tgt);
            r_ox <= w_lv[0]; r_oy <= w_lv[1]; r_oz <= w_lv[2];
        end
    end

    assign o_valid     = r_rv;
    assign o_status    = r_os;
    assign o_out_time  = r_ot;
    assign o_out_vel_x = r_ox;
    assign o_out_vel_y = r_oy;
    assign o_out_vel_z = r_oz;
endmodule
`default_nettype wire

// ===== src/timestamped_velocity_interpolator_unit.sv =====
// ============================================================================
// timestamped_velocity_interpolator_unit
// Time-windowed ring of 3-axis velocity samples with interpolated lookup.
// ============================================================================
//  channel   | handshake              | payload
//  ----------+------------------------+-------------------------------------
//  command   | start / busy           | command, times, in velocities
//  result    | o_valid (one cycle)    | status, out_time, out velocities
//  config    | i_cfg_we               | i_cfg_wdata (window_length)
//
//  An add prunes stale samples, then stores the sample if accepted. A query
//  prunes likewise, reads the oldest and newest entries if any; a time query
//  then scans entry pairs and runs the bit-serial interpolation divide when
//  the target falls between two entries. Reset is synchronous, empties the
//  ring and holds busy high; results cannot be stalled.
// ============================================================================
`default_nettype none
module timestamped_velocity_interpolator_unit #(
    parameter int unsigned DEPTH     = tvi_pkg::DEPTH_DEF,
    parameter int unsigned TIME_BITS = tvi_pkg::TIME_BITS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [31:0] i_cfg_wdata,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [1:0]  i_command,
    input  wire logic [31:0] i_now_time,
    input  wire logic [31:0] i_sample_time,
    input  wire logic [31:0] i_in_vel_x,
    input  wire logic [31:0] i_in_vel_y,
    input  wire logic [31:0] i_in_vel_z,
    input  wire logic [31:0] i_target_time,
    output logic             o_valid,
    output logic [1:0]       o_status,
    output logic [31:0]      o_out_time,
    output logic [31:0]      o_out_vel_x,
    output logic [31:0]      o_out_vel_y,
    output logic [31:0]      o_out_vel_z
);
    import tvi_pkg::*;
    t_ctl w_ctl;
    t_sts w_sts;

    tvi_ctrl u_ctrl (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_start (start),
        .i_sts (w_sts), .o_ctl (w_ctl), .o_busy (busy)
    );

    tvi_dpath #(.DEPTH(DEPTH), .TIME_BITS(TIME_BITS)) u_dpath (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_ctl (w_ctl), .o_sts (w_sts),
        .i_cfg_we (i_cfg_we), .i_cfg_wdata (i_cfg_wdata),
        .i_command (i_command), .i_now_time (i_now_time),
        .i_sample_time (i_sample_time), .i_in_vel_x (i_in_vel_x),
        .i_in_vel_y (i_in_vel_y), .i_in_vel_z (i_in_vel_z),
        .i_target_time (i_target_time), .o_valid (o_valid),
        .o_status (o_status), .o_out_time (o_out_time),
        .o_out_vel_x (o_out_vel_x), .o_out_vel_y (o_out_vel_y),
        .o_out_vel_z (o_out_vel_z)
    );
endmodule
`default_nettype wire
